// ----- design/tvne_pkg.sv -----
`timescale 1ns / 1ps
// tvne_pkg: shared constants, action codes and vector types of the vertex normal engine
// no dependencies; imported by tvne_unit and the top level
package tvne_pkg;

	localparam int IDX_W   = 12;
	localparam int POS_W   = 16;
	localparam int NRM_W   = 16;
	localparam int EDGE_W  = 17;
	// signed width of a vector fed to the unit scaler, and of its magnitudes
	localparam int VEC_W   = 35;
	localparam int MAG_W   = 34;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int SUM_WIDTH_DEF    = 24;

	localparam logic [14:0] ONE_Q14 = 15'd16384;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_TRI   = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	typedef struct packed {
		logic signed [VEC_W-1:0] z;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] x;
	} vec_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] z;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] x;
	} nrm_t;

endpackage

// ----- design/triangle_vertex_normal_engine_top.sv -----
`timescale 1ns / 1ps
// triangle_vertex_normal_engine_top: command decode, vertex and sum memories, cross product
// depends on tvne_pkg, tvne_ram and tvne_unit
//
// Per-vertex normal engine for an indexed triangle mesh.
// Commands come in on the s_axis channel: tuser is the action (clear, write vertex,
// add triangle, read normal), tdata the three indexes and a Q7.8 position.
// Read normal returns one word on m_axis: the index and a Q1.14 unit normal.
// A read normal also waits for the output register while it holds an unaccepted word.
// The scaler unit works in steps: normalizing shifts, a sum of squares, an integer
// root and three divides; a degenerate face or a zero sum skips them. The cross
// product runs six products through one 17x17 multiplier; each corner update is a
// read-modify-write of the sum memory.
// Clear, and also reset, sweep the sum memory one entry a cycle, during which no
// command is taken; cfg_we writes are taken at any time.
// s_axis_tready is high only while no command is in progress. A finished word waits
// in the output register; a new command is accepted meanwhile, and only the next
// read result waits for the register to free up when m_axis_tready is low.
// invert_output resets to 1 and negates returned normals.
module triangle_vertex_normal_engine_top #(
	parameter int MAX_VERTICES = tvne_pkg::MAX_VERTICES_DEF,
	parameter int SUM_WIDTH    = tvne_pkg::SUM_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// index_a, index_b, index_c, pos_x, pos_y, pos_z, zero pad
	input  logic [87:0] s_axis_tdata,
	// action
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_index, normal_x, normal_y, normal_z, zero pad
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	import tvne_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int VW = 3 * POS_W;
	localparam int SW = 3 * SUM_WIDTH;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_VA, ST_VB, ST_VC, ST_VD, ST_CROSS,
		ST_RDS, ST_RDS2, ST_UNIT, ST_ACCR, ST_ACCW, ST_OUT
	} state_t;

	state_t                   state_q;
	logic                     invert_q;
	logic                     is_read_q;
	logic                     rng_q;
	logic [AW-1:0]            clr_q;
	logic [IDX_W-1:0]         ia_q, ib_q, ic_q;
	logic [VW-1:0]            va_q, vb_q;
	logic signed [EDGE_W-1:0] e1_q [3];
	logic signed [EDGE_W-1:0] e2_q [3];
	logic signed [2*EDGE_W-1:0] prod_q;
	logic signed [VEC_W-1:0]  cr_q [3];
	logic [2:0]               cnt_q;
	logic [1:0]               corner_q;
	logic                     m_valid_q;
	logic [63:0]              m_data_q;

	logic                     accept;
	logic [1:0]               act;
	logic [IDX_W-1:0]         in_a, in_b, in_c;
	logic                     rng_a, rng_b, rng_c;
	logic                     vert_we;
	logic [AW-1:0]            vert_raddr;
	logic [VW-1:0]            vert_rdata;
	logic                     sum_we;
	logic [AW-1:0]            sum_waddr, sum_raddr;
	logic [SW-1:0]            sum_wdata, sum_rdata;
	logic [IDX_W-1:0]         corner_idx;
	logic signed [EDGE_W-1:0] mul_a, mul_b;
	logic [2:0]               k;
	logic                     u_start;
	logic                     u_done;
	vec_t                     u_vec;
	nrm_t                     u_nrm;
	logic signed [SUM_WIDTH-1:0] sum_old [3];
	logic signed [SUM_WIDTH-1:0] sum_new [3];
	logic signed [SUM_WIDTH:0]   sum_ext [3];
	logic signed [NRM_W-1:0]     nrm_c [3];
	logic signed [NRM_W-1:0]     out_n [3];

	// input decode
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign act           = s_axis_tuser;
	assign in_a          = s_axis_tdata[11:0];
	assign in_b          = s_axis_tdata[23:12];
	assign in_c          = s_axis_tdata[35:24];
	assign rng_a         = (32'(in_a) < 32'(MAX_VERTICES));
	assign rng_b         = (32'(in_b) < 32'(MAX_VERTICES));
	assign rng_c         = (32'(in_c) < 32'(MAX_VERTICES));
	assign vert_we       = accept && (act == ACT_WRITE) && rng_a;

	// vertex store read address follows the corner being fetched
	always_comb begin
		unique case (state_q)
			ST_VB:   vert_raddr = AW'(ib_q);
			ST_VC:   vert_raddr = AW'(ic_q);
			default: vert_raddr = AW'(ia_q);
		endcase
	end

	tvne_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vert_ram (
		.clk   (clk),
		.we    (vert_we),
		.waddr (AW'(in_a)),
		.wdata (s_axis_tdata[83:36]),
		.raddr (vert_raddr),
		.rdata (vert_rdata)
	);

	// corner selection for the accumulate phase
	always_comb begin
		case (corner_q)
			2'd0:    corner_idx = ia_q;
			2'd1:    corner_idx = ib_q;
			default: corner_idx = ic_q;
		endcase
	end

	// saturating add of the face normal into the old sums
	always_comb begin
		nrm_c[0] = u_nrm.x;
		nrm_c[1] = u_nrm.y;
		nrm_c[2] = u_nrm.z;
		for (int i = 0; i < 3; i++) begin
			sum_old[i] = sum_rdata[i*SUM_WIDTH +: SUM_WIDTH];
			sum_ext[i] = (SUM_WIDTH+1)'(sum_old[i]) + (SUM_WIDTH+1)'(nrm_c[i]);
			if (sum_ext[i][SUM_WIDTH] != sum_ext[i][SUM_WIDTH-1]) begin
				sum_new[i] = sum_ext[i][SUM_WIDTH] ?
					{1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
			end else begin
				sum_new[i] = sum_ext[i][SUM_WIDTH-1:0];
			end
			out_n[i] = invert_q ? -nrm_c[i] : nrm_c[i];
		end
	end

	// sum store ports: clearing sweep or corner update
	always_comb begin
		sum_we    = (state_q == ST_CLR) || (state_q == ST_ACCW);
		sum_waddr = (state_q == ST_CLR) ? clr_q : AW'(corner_idx);
		sum_wdata = (state_q == ST_CLR) ? '0 : {sum_new[2], sum_new[1], sum_new[0]};
		sum_raddr = (state_q == ST_ACCR) ? AW'(corner_idx) : AW'(ia_q);
	end

	tvne_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// cross product operand schedule
	assign k = cnt_q - 3'd1;
	always_comb begin
		case (cnt_q)
			3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			3'd5:    begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
			default: begin mul_a = '0;      mul_b = '0;      end
		endcase
	end

	// scaler input: sums for a read, cross product for a triangle
	always_comb begin
		u_start = ((state_q == ST_CROSS) && (cnt_q == 3'd7)) || (state_q == ST_RDS2);
		if (state_q == ST_RDS2) begin
			if (rng_q) begin
				u_vec.x = VEC_W'($signed(sum_rdata[0*SUM_WIDTH +: SUM_WIDTH]));
				u_vec.y = VEC_W'($signed(sum_rdata[1*SUM_WIDTH +: SUM_WIDTH]));
				u_vec.z = VEC_W'($signed(sum_rdata[2*SUM_WIDTH +: SUM_WIDTH]));
			end else begin
				u_vec = '0;
			end
		end else begin
			u_vec.x = cr_q[0];
			u_vec.y = cr_q[1];
			u_vec.z = cr_q[2];
		end
	end

	tvne_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (u_start),
		.vec_in  (u_vec),
		.done    (u_done),
		.nrm_out (u_nrm)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b1;
		end else if (cfg_we) begin
			invert_q <= cfg_wdata;
		end
	end

	// command sequencer, datapath registers and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			cnt_q     <= '0;
			corner_q  <= '0;
			is_read_q <= 1'b0;
			rng_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// the output state handles its own load and release
			if (m_axis_tready && (state_q != ST_OUT)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_VERTICES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ia_q  <= in_a;
						ib_q  <= in_b;
						ic_q  <= in_c;
						rng_q <= rng_a;
						unique case (act)
							ACT_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							ACT_WRITE: begin
								state_q <= ST_IDLE;
							end
							ACT_TRI: begin
								is_read_q <= 1'b0;
								if (rng_a && rng_b && rng_c) begin
									state_q <= ST_VA;
								end
							end
							ACT_READ: begin
								is_read_q <= 1'b1;
								state_q   <= ST_RDS;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_VA: state_q <= ST_VB;
				ST_VB: begin
					va_q    <= vert_rdata;
					state_q <= ST_VC;
				end
				ST_VC: begin
					vb_q    <= vert_rdata;
					state_q <= ST_VD;
				end
				// edge vectors from corner a
				ST_VD: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= EDGE_W'($signed(vb_q[i*POS_W +: POS_W]))
							- EDGE_W'($signed(va_q[i*POS_W +: POS_W]));
						e2_q[i] <= EDGE_W'($signed(vert_rdata[i*POS_W +: POS_W]))
							- EDGE_W'($signed(va_q[i*POS_W +: POS_W]));
					end
					cnt_q   <= '0;
					state_q <= ST_CROSS;
				end
				// six products, each pair folded into one component
				ST_CROSS: begin
					prod_q <= mul_a * mul_b;
					if ((cnt_q != 3'd0) && (cnt_q != 3'd7)) begin
						if (!k[0]) begin
							cr_q[k[2:1]] <= VEC_W'(prod_q);
						end else begin
							cr_q[k[2:1]] <= cr_q[k[2:1]] - VEC_W'(prod_q);
						end
					end
					if (cnt_q == 3'd7) begin
						state_q <= ST_UNIT;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_RDS: state_q <= ST_RDS2;
				ST_RDS2: state_q <= ST_UNIT;
				ST_UNIT: begin
					if (u_done) begin
						corner_q <= '0;
						state_q  <= is_read_q ? ST_OUT : ST_ACCR;
					end
				end
				ST_ACCR: state_q <= ST_ACCW;
				ST_ACCW: begin
					if (corner_q == 2'd2) begin
						state_q <= ST_IDLE;
					end else begin
						corner_q <= corner_q + 2'd1;
						state_q  <= ST_ACCR;
					end
				end
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_data_q  <= {4'd0, out_n[2], out_n[1], out_n[0], ia_q};
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// the scaler finishes only while the sequencer waits on it
	a_done_in_unit: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> (state_q == ST_UNIT))
		else $error("scaler done outside of wait state");

	// vertex writes happen only with an accepted command word
	a_vert_we: assert property (@(posedge clk) disable iff (!arst_n)
		vert_we |-> (s_axis_tvalid && (state_q == ST_IDLE)))
		else $error("vertex write without accepted word");

	// a new result word is loaded only from the output state
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_OUT))
		else $error("result word loaded outside output state");

	// the returned x component stays within unit range
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[27:12]) <= 16'sd16384
			&& $signed(m_axis_tdata[27:12]) >= -16'sd16384))
		else $error("normal x out of unit range");

endmodule

// ----- design/tvne_ram.sv -----
`timescale 1ns / 1ps
// tvne_ram: generic single write port, single read port ram with registered read
// no dependencies
module tvne_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/tvne_unit.sv -----
`timescale 1ns / 1ps
// tvne_unit: iterative unit-length scaler, one shift, multiply, root or divide step a cycle
// depends on tvne_pkg
module tvne_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tvne_pkg::vec_t vec_in,
	output logic          done,
	output tvne_pkg::nrm_t nrm_out
);

	import tvne_pkg::*;

	typedef enum logic [2:0] {
		U_IDLE, U_NORM, U_SQ, U_ROOT, U_DIVSET, U_DIV, U_DONE
	} ustate_t;

	ustate_t             state_q;
	logic [MAG_W-1:0]    m_q [3];
	logic [2:0]          neg_q;
	logic [61:0]         s_q;
	logic [61:0]         rt_q;
	logic [61:0]         bit_q;
	logic [59:0]         prod_q;
	logic [4:0]          cnt_q;
	logic [1:0]          comp_q;
	logic [44:0]         rem_q;
	logic [44:0]         div_q;
	logic [14:0]         quo_q;
	nrm_t                nrm_q;

	logic [MAG_W-1:0]    m_in [3];
	logic [2:0]          neg_in;
	logic [MAG_W-1:0]    mx_in;
	logic [MAG_W-1:0]    mx;
	logic [29:0]         sq_op;
	logic [29:0]         div_m;
	logic [61:0]         rt_try;
	logic [14:0]         quo_n;
	logic [14:0]         quo_c;
	logic [NRM_W-1:0]    res;
	logic                res_neg;
	logic signed [VEC_W-1:0] vin [3];

	// magnitudes and signs of the incoming vector
	always_comb begin
		vin[0] = vec_in.x;
		vin[1] = vec_in.y;
		vin[2] = vec_in.z;
		for (int i = 0; i < 3; i++) begin
			neg_in[i] = vin[i][VEC_W-1];
			m_in[i]   = neg_in[i] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
		end
		mx_in = (m_in[0] > m_in[1]) ? m_in[0] : m_in[1];
		mx_in = (m_in[2] > mx_in) ? m_in[2] : mx_in;
		mx    = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
		mx    = (m_q[2] > mx) ? m_q[2] : mx;
	end

	// operand selection for the square and divide steps
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_op = m_q[0][29:0];
			2'd1:    sq_op = m_q[1][29:0];
			default: sq_op = m_q[2][29:0];
		endcase
		case (comp_q)
			2'd0:    div_m = m_q[0][29:0];
			2'd1:    div_m = m_q[1][29:0];
			default: div_m = m_q[2][29:0];
		endcase
		res_neg = neg_q[comp_q];
		rt_try  = rt_q + bit_q;
		quo_n   = (rem_q >= div_q) ? {quo_q[13:0], 1'b1} : {quo_q[13:0], 1'b0};
		quo_c   = (quo_n > ONE_Q14) ? ONE_Q14 : quo_n;
		res     = res_neg ? NRM_W'(-{1'b0, quo_c}) : NRM_W'({1'b0, quo_c});
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						neg_q <= neg_in;
						for (int i = 0; i < 3; i++) m_q[i] <= m_in[i];
						if (mx_in == '0) begin
							nrm_q   <= '0;
							state_q <= U_DONE;
						end else begin
							state_q <= U_NORM;
						end
					end
				end
				// bring the largest magnitude into [2^29, 2^30)
				U_NORM: begin
					if (|mx[MAG_W-1:30]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (!mx[29]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						s_q     <= '0;
						cnt_q   <= '0;
						state_q <= U_SQ;
					end
				end
				// sum of squares through one multiplier
				U_SQ: begin
					if (cnt_q < 5'd3) begin
						prod_q <= sq_op * sq_op;
					end
					if (cnt_q != 5'd0) begin
						s_q <= s_q + 62'(prod_q);
					end
					if (cnt_q == 5'd3) begin
						rt_q    <= '0;
						bit_q   <= 62'd1 << 60;
						state_q <= U_ROOT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				// digit-by-digit integer root, one bit a cycle
				U_ROOT: begin
					if (s_q >= rt_try) begin
						s_q  <= s_q - rt_try;
						rt_q <= (rt_q >> 1) + bit_q;
					end else begin
						rt_q <= rt_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						comp_q  <= '0;
						state_q <= U_DIVSET;
					end
				end
				U_DIVSET: begin
					rem_q   <= 45'({div_m, 14'd0}) + 45'(rt_q[30:1]);
					div_q   <= 45'({rt_q[30:0], 14'd0});
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= U_DIV;
				end
				// restoring divide, one quotient bit a cycle
				U_DIV: begin
					if (rem_q >= div_q) begin
						rem_q <= rem_q - div_q;
					end
					div_q <= div_q >> 1;
					quo_q <= quo_n;
					if (cnt_q == 5'd14) begin
						case (comp_q)
							2'd0:    nrm_q.x <= res;
							2'd1:    nrm_q.y <= res;
							default: nrm_q.z <= res;
						endcase
						if (comp_q == 2'd2) begin
							state_q <= U_DONE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= U_DIVSET;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				U_DONE: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign done    = (state_q == U_DONE);
	assign nrm_out = nrm_q;

endmodule
